### rtl/sefd_pkg.sv
// Package for the SOI/EOI frame delimiter: marker codes, reset values and result type.
// Used by sefd_out_fifo and jpeg_soi_eoi_frame_delimiter.
package sefd_pkg;

    localparam logic [7:0]  MARK_LEAD       = 8'hFF;
    localparam logic [7:0]  MARK_SOI        = 8'hD8;
    localparam logic [7:0]  MARK_EOI        = 8'hD9;

    localparam int          LENGTH_BITS_DEF = 20;
    localparam int          CFG_W           = 20;
    localparam int          OUT_LEN_W       = 20;
    localparam int          INDEX_W         = 32;
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(100 * 1024 - 1024);

    localparam int          FIFO_DEPTH      = 4;
    localparam int          FIFO_PTR_W      = $clog2(FIFO_DEPTH);
    localparam int          FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [INDEX_W-1:0]   frame_index;
        logic [OUT_LEN_W-1:0] frame_length;
        logic                 aborted;
        logic                 frame_end;
        logic                 frame_start;
        logic [7:0]           out_byte;
    } result_t;

endpackage

### rtl/sefd_out_fifo.sv
// Result queue for the frame delimiter: takes up to two results per cycle, hands out one.
// Depends on sefd_pkg.
module sefd_out_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  sefd_pkg::result_t push_data0,
    input  sefd_pkg::result_t push_data1,
    output logic              room_for_two,
    output logic              out_valid,
    input  logic              out_ready,
    output sefd_pkg::result_t out_data
);

    sefd_pkg::result_t                    mem_reg [sefd_pkg::FIFO_DEPTH];
    logic [sefd_pkg::FIFO_PTR_W-1:0]      wr_ptr_reg;
    logic [sefd_pkg::FIFO_PTR_W-1:0]      wr_ptr_next;
    logic [sefd_pkg::FIFO_PTR_W-1:0]      rd_ptr_reg;
    logic [sefd_pkg::FIFO_PTR_W-1:0]      rd_ptr_next;
    logic [sefd_pkg::FIFO_CNT_W-1:0]      count_reg;
    logic [sefd_pkg::FIFO_CNT_W-1:0]      count_next;
    logic                                 pop;

    assign pop          = out_valid && out_ready;
    assign out_valid    = (count_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= sefd_pkg::FIFO_CNT_W'(sefd_pkg::FIFO_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sefd_pkg::FIFO_PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + sefd_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + sefd_pkg::FIFO_CNT_W'(push_cnt)
                      - sefd_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push_data0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[sefd_pkg::FIFO_PTR_W'(wr_ptr_reg + sefd_pkg::FIFO_PTR_W'(1))] <= push_data1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/jpeg_soi_eoi_frame_delimiter.sv
// A result reaches m_axis in the cycle after its input transaction when the result queue is empty;
// after a start marker queues two results, later results wait behind that backlog.
// Throughput: one input transaction per cycle; s_axis_tready drops only when m_axis_tready
// stalls leave more than two of the four queue entries filled.
// Reset: hunting, counters cleared, max_frame_len set to 101376, queue empty.
// Top level of the SOI/EOI frame delimiter; depends on sefd_pkg and sefd_out_fifo.
module jpeg_soi_eoi_frame_delimiter
#(
    parameter int LENGTH_BITS = sefd_pkg::LENGTH_BITS_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [sefd_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]                 s_axis_tuser,   // [0] restart
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [63:0]                m_axis_tdata,   // [7:0] out_byte, [27:8] frame_length,
                                                       // [59:28] frame_index, [63:60] zero
    output logic [1:0]                 m_axis_tuser,   // [0] frame_start, [1] aborted
    output logic                       m_axis_tlast    // frame_end
);

    localparam int CMP_W = ((LENGTH_BITS > sefd_pkg::CFG_W) ? LENGTH_BITS : sefd_pkg::CFG_W) + 1;

    logic [sefd_pkg::CFG_W-1:0]   max_len_reg;
    logic                         in_frame_reg;
    logic                         in_frame_next;
    logic                         prev_ff_reg;
    logic                         prev_ff_next;
    logic [LENGTH_BITS-1:0]       count_reg;
    logic [LENGTH_BITS-1:0]       count_next;
    logic [sefd_pkg::INDEX_W-1:0] frames_reg;
    logic [sefd_pkg::INDEX_W-1:0] frames_next;

    logic                         accept;
    logic                         room_for_two;
    logic [1:0]                   push_cnt;
    sefd_pkg::result_t            push_data0;
    sefd_pkg::result_t            push_data1;
    sefd_pkg::result_t            out_data;

    logic [CMP_W-1:0]             next_len;
    logic [CMP_W-1:0]             len_mask;
    logic                         over_mask;
    logic                         overflow;
    logic [7:0]                   data_byte;
    logic                         restart;

    assign s_axis_tready = room_for_two;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign data_byte     = s_axis_tdata;
    assign restart       = s_axis_tuser[0];

    assign next_len  = CMP_W'(count_reg) + CMP_W'(1);
    assign len_mask  = CMP_W'({LENGTH_BITS{1'b1}});
    assign over_mask = (next_len > len_mask);
    assign overflow  = (next_len > CMP_W'(max_len_reg)) || over_mask;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        prev_ff_next  = prev_ff_reg;
        count_next    = count_reg;
        frames_next   = frames_reg;
        push_cnt      = 2'd0;

        push_data0              = '0;
        push_data0.frame_index  = frames_reg;
        push_data0.out_byte     = data_byte;
        push_data0.frame_length = sefd_pkg::OUT_LEN_W'(next_len);
        push_data1              = '0;
        push_data1.frame_index  = frames_reg;
        push_data1.out_byte     = sefd_pkg::MARK_SOI;
        push_data1.frame_length = sefd_pkg::OUT_LEN_W'(2);

        if (accept)
        begin
            if (restart)
            begin
                if (in_frame_reg)
                begin
                    push_cnt                = 2'd1;
                    push_data0.out_byte     = 8'h00;
                    push_data0.frame_end    = 1'b1;
                    push_data0.aborted      = 1'b1;
                    push_data0.frame_length = sefd_pkg::OUT_LEN_W'(CMP_W'(count_reg));
                end
                in_frame_next = 1'b0;
                prev_ff_next  = 1'b0;
                count_next    = '0;
            end
            else if (!in_frame_reg)
            begin
                if (prev_ff_reg && (data_byte == sefd_pkg::MARK_SOI))
                begin
                    push_cnt                = 2'd2;
                    push_data0.out_byte     = sefd_pkg::MARK_LEAD;
                    push_data0.frame_start  = 1'b1;
                    push_data0.frame_length = sefd_pkg::OUT_LEN_W'(1);
                    in_frame_next           = 1'b1;
                    prev_ff_next            = 1'b0;
                    count_next              = LENGTH_BITS'(2);
                end
                else
                begin
                    prev_ff_next = (data_byte == sefd_pkg::MARK_LEAD);
                end
            end
            else
            begin
                push_cnt = 2'd1;
                if (overflow)
                begin
                    push_data0.frame_end    = 1'b1;
                    push_data0.aborted      = 1'b1;
                    push_data0.frame_length = over_mask
                                              ? sefd_pkg::OUT_LEN_W'(len_mask)
                                              : sefd_pkg::OUT_LEN_W'(next_len);
                    in_frame_next           = 1'b0;
                    prev_ff_next            = 1'b0;
                    count_next              = '0;
                end
                else if (prev_ff_reg && (data_byte == sefd_pkg::MARK_EOI))
                begin
                    push_data0.frame_end = 1'b1;
                    frames_next          = frames_reg + sefd_pkg::INDEX_W'(1);
                    in_frame_next        = 1'b0;
                    prev_ff_next         = 1'b0;
                    count_next           = '0;
                end
                else
                begin
                    count_next   = LENGTH_BITS'(next_len);
                    prev_ff_next = (data_byte == sefd_pkg::MARK_LEAD);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= sefd_pkg::MAX_LEN_RESET;
            in_frame_reg <= 1'b0;
            prev_ff_reg  <= 1'b0;
            count_reg    <= '0;
            frames_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            in_frame_reg <= in_frame_next;
            prev_ff_reg  <= prev_ff_next;
            count_reg    <= count_next;
            frames_reg   <= frames_next;
        end
    end

    sefd_out_fifo u_out_fifo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .push_data0   (push_data0),
        .push_data1   (push_data1),
        .room_for_two (room_for_two),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_data     (out_data)
    );

    assign m_axis_tdata = {4'h0, out_data.frame_index, out_data.frame_length, out_data.out_byte};
    assign m_axis_tuser = {out_data.aborted, out_data.frame_start};
    assign m_axis_tlast = out_data.frame_end;

endmodule

### test/jpeg_soi_eoi_frame_delimiter_test.sv
`timescale 1ns / 100ps
// Self-checking bench for jpeg_soi_eoi_frame_delimiter: random and directed MJPEG byte streams,
// results predicted per transaction and compared field by field. Depends on sefd_pkg.
module jpeg_soi_eoi_frame_delimiter_test;

    localparam int unsigned LEN_MAX = (1 << sefd_pkg::LENGTH_BITS_DEF) - 1;
    localparam int unsigned HOLD_CYCLES = 300;

    typedef struct packed {
        logic       restart;
        logic [7:0] data;
    } stream_item_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [sefd_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [7:0]                 s_axis_tdata = '0;
    logic [0:0]                 s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [63:0]                m_axis_tdata;
    logic [1:0]                 m_axis_tuser;
    logic                       m_axis_tlast;

    stream_item_t               pending_bytes[$];
    sefd_pkg::result_t          frame_results[$];
    stream_item_t               next_item;

    logic                       in_frame = 1'b0;
    logic                       saw_lead = 1'b0;
    int unsigned                frame_bytes = 0;
    logic [31:0]                frames_done = '0;
    int unsigned                len_limit = sefd_pkg::MAX_LEN_RESET;

    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;
    logic                       hold_req = 1'b0;
    int unsigned                hold_left = 0;
    logic                       failed = 1'b0;

    jpeg_soi_eoi_frame_delimiter uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    function automatic void push_result(input logic [7:0] b, input logic st, input logic en,
                                        input logic ab, input int unsigned len);
        sefd_pkg::result_t r;
        r.out_byte     = b;
        r.frame_start  = st;
        r.frame_end    = en;
        r.aborted      = ab;
        r.frame_length = sefd_pkg::OUT_LEN_W'(len);
        r.frame_index  = frames_done;
        frame_results.push_back(r);
    endfunction

    function automatic void predict_delimiter(input logic [7:0] b, input logic restart);
        int unsigned next_len;
        if (restart)
        begin
            if (in_frame)
                push_result(8'h00, 1'b0, 1'b1, 1'b1, frame_bytes);
            in_frame    = 1'b0;
            saw_lead    = 1'b0;
            frame_bytes = 0;
            return;
        end
        if (!in_frame)
        begin
            if (saw_lead && b == sefd_pkg::MARK_SOI)
            begin
                in_frame = 1'b1;
                saw_lead = 1'b0;
                push_result(sefd_pkg::MARK_LEAD, 1'b1, 1'b0, 1'b0, 1);
                frame_bytes = 2;
                push_result(sefd_pkg::MARK_SOI, 1'b0, 1'b0, 1'b0, frame_bytes);
            end
            else
            begin
                saw_lead = (b == sefd_pkg::MARK_LEAD);
            end
            return;
        end
        next_len = frame_bytes + 1;
        if (next_len > len_limit || next_len > LEN_MAX)
        begin
            push_result(b, 1'b0, 1'b1, 1'b1, (next_len > LEN_MAX) ? LEN_MAX : next_len);
            in_frame    = 1'b0;
            saw_lead    = 1'b0;
            frame_bytes = 0;
        end
        else if (saw_lead && b == sefd_pkg::MARK_EOI)
        begin
            push_result(b, 1'b0, 1'b1, 1'b0, next_len);
            frames_done = frames_done + 1;
            in_frame    = 1'b0;
            saw_lead    = 1'b0;
            frame_bytes = 0;
        end
        else
        begin
            frame_bytes = next_len;
            push_result(b, 1'b0, 1'b0, 1'b0, next_len);
            saw_lead = (b == sefd_pkg::MARK_LEAD);
        end
    endfunction

    function automatic logic [7:0] stream_byte();
        case ($urandom_range(0, 11))
            0, 1:    return sefd_pkg::MARK_LEAD;
            2:       return sefd_pkg::MARK_SOI;
            3:       return sefd_pkg::MARK_EOI;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic add_item(input logic [7:0] b, input logic restart);
        stream_item_t it;
        it.data    = b;
        it.restart = restart;
        pending_bytes.push_back(it);
    endtask

    task automatic queue_frames(input int budget);
        int placed;
        int body;
        placed = 0;
        while (placed < budget)
        begin
            repeat ($urandom_range(0, 3))
                add_item(stream_byte(), 1'b0);
            if ($urandom_range(0, 19) == 0)
                add_item(8'($urandom), 1'b1);
            add_item(sefd_pkg::MARK_LEAD, 1'b0);
            add_item(sefd_pkg::MARK_SOI, 1'b0);
            body = $urandom_range(0, 24);
            repeat (body)
                add_item(stream_byte(), $urandom_range(0, 99) == 0);
            case ($urandom_range(0, 9))
                0:       add_item(8'($urandom), 1'b1);
                1:       ;
                default:
                begin
                    add_item(sefd_pkg::MARK_LEAD, 1'b0);
                    add_item(sefd_pkg::MARK_EOI, 1'b0);
                end
            endcase
            placed += body + 4;
        end
    endtask

    task automatic wait_drained();
        int spins;
        spins = 0;
        do
        begin
            @(posedge clk);
            #1;
            spins++;
        end
        while ((pending_bytes.size() != 0 || s_axis_tvalid || frame_results.size() != 0)
               && spins < 50000);
        if (frame_results.size() != 0)
        begin
            $error("%0d expected results never arrived", frame_results.size());
            failed = 1'b1;
            frame_results.delete();
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [sefd_pkg::CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        len_limit    = 32'(value);
    endtask

    // Source side: hold the offered transaction until accepted, then advance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_delimiter(s_axis_tdata, s_axis_tuser[0]);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_item.data;
                    s_axis_tuser  <= next_item.restart;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= HOLD_CYCLES;
    end

    // Sink side: compare each transaction with the oldest predicted result.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (frame_results.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h", m_axis_tdata[7:0]);
                    failed = 1'b1;
                end
                else
                begin
                    sefd_pkg::result_t want;
                    want = frame_results.pop_front();
                    if (m_axis_tdata[7:0] !== want.out_byte)
                    begin
                        $error("out_byte: expected %0h, got %0h",
                               want.out_byte, m_axis_tdata[7:0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser[0] !== want.frame_start)
                    begin
                        $error("frame_start: expected %0b, got %0b",
                               want.frame_start, m_axis_tuser[0]);
                        failed = 1'b1;
                    end
                    if (m_axis_tlast !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, m_axis_tlast);
                        failed = 1'b1;
                    end
                    if (m_axis_tuser[1] !== want.aborted)
                    begin
                        $error("aborted: expected %0b, got %0b", want.aborted, m_axis_tuser[1]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[27:8] !== want.frame_length)
                    begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, m_axis_tdata[27:8]);
                        failed = 1'b1;
                    end
                    if (m_axis_tdata[59:28] !== want.frame_index)
                    begin
                        $error("frame_index: expected %0d, got %0d",
                               want.frame_index, m_axis_tdata[59:28]);
                        failed = 1'b1;
                    end
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #8_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // hunting restart, start marker, D9 right after start, FF D8 inside a frame, end marker
        add_item(8'hA5, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_SOI, 1'b0);
        add_item(sefd_pkg::MARK_EOI, 1'b0);
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_SOI, 1'b0);
        add_item(8'h7F, 1'b0);
        add_item(8'h80, 1'b0);
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_EOI, 1'b0);
        // repeated lead byte before start, restart inside a frame
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_SOI, 1'b0);
        add_item(8'h55, 1'b0);
        add_item(8'h00, 1'b1);
        wait_drained();

        // smallest limit: a bare marker pair fits, one more byte overflows
        write_max_len(sefd_pkg::CFG_W'(4));
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_SOI, 1'b0);
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_EOI, 1'b0);
        add_item(sefd_pkg::MARK_LEAD, 1'b0);
        add_item(sefd_pkg::MARK_SOI, 1'b0);
        add_item(8'h01, 1'b0);
        add_item(8'hFE, 1'b0);
        add_item(8'h03, 1'b0);
        queue_frames(150);
        wait_drained();

        send_idle_pct  = 83;
        recv_stall_pct = 0;
        write_max_len(sefd_pkg::CFG_W'(LEN_MAX));
        queue_frames(380);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 83;
        write_max_len(sefd_pkg::CFG_W'($urandom_range(4, 40)));
        queue_frames(380);
        wait_drained();

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        write_max_len(sefd_pkg::CFG_W'(20));
        queue_frames(380);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_max_len(sefd_pkg::MAX_LEN_RESET);
        queue_frames(500);
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        wait_drained();

        if (!failed)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

### jpeg_soi_eoi_frame_delimiter.f
rtl/sefd_pkg.sv
rtl/sefd_out_fifo.sv
rtl/jpeg_soi_eoi_frame_delimiter.sv
test/jpeg_soi_eoi_frame_delimiter_test.sv
